// ===== rtl/gnig_pkg.sv =====
package gnig_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned INDEX_W = 20;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_DIM_DEFAULT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 2'd2;

  localparam logic [DIM_W-1:0] DIM_MIN         = 11'd2;
  localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 11'd2;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 11'd2;
  localparam logic             WRAP_MODE_RST   = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_NONE   = 3'd0;
  localparam logic [COUNT_W-1:0] COUNT_CORNER = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_EDGE   = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_FULL   = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [INDEX_W-1:0] row_base;
    logic [DIM_W-1:0]   w;
    logic               inr;
    logic               bot;
    logic               top;
    logic               lft;
    logic               rgt;
    logic               wrap;
  } stage_t;

endpackage

// ===== rtl/grid_neighbor_index_generator.sv =====
// throughput: one transaction per cycle while out_ready is high; stage 1 holds
// the row times width product, stage 2 the index adds and slot selection
// reset (synchronous, active high) empties both stages and sets
// grid_width 2, grid_height 2, wrap_mode 1
module grid_neighbor_index_generator
  import gnig_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   column,
  input  logic [COORD_W-1:0]   row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [INDEX_W-1:0]   cell_index,
  output logic [INDEX_W-1:0]   neighbor_0,
  output logic [INDEX_W-1:0]   neighbor_1,
  output logic [INDEX_W-1:0]   neighbor_2,
  output logic [INDEX_W-1:0]   neighbor_3,
  output logic [COUNT_W-1:0]   neighbor_count,
  output logic                 in_range
);

  localparam logic [16:0] MaxDim = 17'(MAX_DIM);

  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic             wrap_mode;
  logic [INDEX_W-1:0] last_row_base;

  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic [2*DIM_W-1:0] last_row_full;

  logic   v1;
  stage_t s1;
  stage_t s1_next;
  logic   ready1;
  logic [COORD_W+DIM_W-1:0] prod_full;

  logic [INDEX_W-1:0] x20, w20, cell_idx, up, down, right, left;
  logic [INDEX_W-1:0] nb0_next, nb1_next, nb2_next, nb3_next;
  logic [COUNT_W-1:0] count_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (grid_width < DIM_MIN) begin
      eff_w = DIM_MIN;
    end else if ({6'b0, grid_width} > MaxDim) begin
      eff_w = MaxDim[DIM_W-1:0];
    end else begin
      eff_w = grid_width;
    end
    if (grid_height < DIM_MIN) begin
      eff_h = DIM_MIN;
    end else if ({6'b0, grid_height} > MaxDim) begin
      eff_h = MaxDim[DIM_W-1:0];
    end else begin
      eff_h = grid_height;
    end
  end

  assign last_row_full = (eff_h - 11'd1) * eff_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      wrap_mode   <= WRAP_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        REG_WRAP_MODE:   wrap_mode   <= cfg_data[0];
        default: ;
      endcase
    end
    last_row_base <= last_row_full[INDEX_W-1:0];
  end

  // stage 1: product and border flags
  assign ready1   = !out_valid || out_ready;
  assign in_ready = !v1 || ready1;

  assign prod_full = {11'b0, row} * {10'b0, eff_w};

  always_comb begin
    s1_next.x        = column;
    s1_next.row_base = prod_full[INDEX_W-1:0];
    s1_next.w        = eff_w;
    s1_next.inr      = ({1'b0, column} < eff_w) && ({1'b0, row} < eff_h);
    s1_next.bot      = (row == '0);
    s1_next.top      = ({1'b0, row} == eff_h - 11'd1);
    s1_next.lft      = (column == '0);
    s1_next.rgt      = ({1'b0, column} == eff_w - 11'd1);
    s1_next.wrap     = wrap_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1 <= s1_next;
    end
  end

  // stage 2: neighbor indices and slot order
  always_comb begin
    x20      = {10'b0, s1.x};
    w20      = {9'b0, s1.w};
    cell_idx = s1.row_base + x20;
    up       = cell_idx + w20;
    down     = cell_idx - w20;
    right    = cell_idx + 20'd1;
    left     = cell_idx - 20'd1;
    nb0_next   = '0;
    nb1_next   = '0;
    nb2_next   = '0;
    nb3_next   = '0;
    count_next = COUNT_NONE;
    if (s1.wrap) begin
      nb0_next   = s1.top ? x20 : up;
      nb1_next   = s1.bot ? (x20 + last_row_base) : down;
      nb2_next   = s1.rgt ? s1.row_base : right;
      nb3_next   = s1.lft ? (s1.row_base + w20 - 20'd1) : left;
      count_next = COUNT_FULL;
    end else if ((s1.bot || s1.top) && (s1.lft || s1.rgt)) begin
      nb0_next   = s1.lft ? right : left;
      nb1_next   = s1.bot ? up : down;
      count_next = COUNT_CORNER;
    end else if (s1.bot) begin
      nb0_next   = up;
      nb1_next   = left;
      nb2_next   = right;
      count_next = COUNT_EDGE;
    end else if (s1.top) begin
      nb0_next   = down;
      nb1_next   = left;
      nb2_next   = right;
      count_next = COUNT_EDGE;
    end else if (s1.lft) begin
      nb0_next   = up;
      nb1_next   = down;
      nb2_next   = right;
      count_next = COUNT_EDGE;
    end else if (s1.rgt) begin
      nb0_next   = up;
      nb1_next   = down;
      nb2_next   = left;
      count_next = COUNT_EDGE;
    end else begin
      nb0_next   = up;
      nb1_next   = down;
      nb2_next   = right;
      nb3_next   = left;
      count_next = COUNT_FULL;
    end
    if (!s1.inr) begin
      cell_idx   = '0;
      nb0_next   = '0;
      nb1_next   = '0;
      nb2_next   = '0;
      nb3_next   = '0;
      count_next = COUNT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready1) begin
      out_valid <= v1;
    end
    if (ready1 && v1) begin
      cell_index     <= cell_idx;
      neighbor_0     <= nb0_next;
      neighbor_1     <= nb1_next;
      neighbor_2     <= nb2_next;
      neighbor_3     <= nb3_next;
      neighbor_count <= count_next;
      in_range       <= s1.inr;
    end
  end

endmodule

// ===== rtl/gnig_checker.sv =====
module gnig_checker
  import gnig_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [DIM_W-1:0]     cfg_data,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [COORD_W-1:0]   column,
  input logic [COORD_W-1:0]   row,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [INDEX_W-1:0]   cell_index,
  input logic [INDEX_W-1:0]   neighbor_0,
  input logic [INDEX_W-1:0]   neighbor_1,
  input logic [INDEX_W-1:0]   neighbor_2,
  input logic [INDEX_W-1:0]   neighbor_3,
  input logic [COUNT_W-1:0]   neighbor_count,
  input logic                 in_range
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_index) && $stable(neighbor_count))
    else $error("stalled result changed");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> neighbor_count == COUNT_NONE && cell_index == '0
      && neighbor_0 == '0 && neighbor_1 == '0)
    else $error("outside coordinate gave nonzero result");

  a_inside_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_range |-> neighbor_count == COUNT_CORNER
      || neighbor_count == COUNT_EDGE || neighbor_count == COUNT_FULL)
    else $error("bad neighbor count");

  // unused slots read as zero
  a_unused_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && neighbor_count != COUNT_FULL |-> neighbor_3 == '0)
    else $error("unused slot not zero");

endmodule

bind grid_neighbor_index_generator gnig_checker u_gnig_checker (.*);

// ===== dv/tb_grid_neighbor_index_generator.sv =====
`timescale 1ns / 100ps

module tb_grid_neighbor_index_generator;
  import gnig_pkg::*;

  localparam int unsigned MAX_DIM = MAX_DIM_DEFAULT;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned NUM_PHASES = 12;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct packed {
    logic [INDEX_W-1:0]        cell_idx;
    logic [3:0][INDEX_W-1:0]   nb;
    logic [COUNT_W-1:0]        count;
    logic                      inr;
  } neighbor_result_t;

  class neighbor_scoreboard;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             wrap;
    neighbor_result_t expected_cells[$];
    int unsigned      errors;

    function new();
      width_reg  = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      wrap       = WRAP_MODE_RST;
      errors     = 0;
    endfunction

    function int unsigned dim_of(logic [DIM_W-1:0] v);
      if (v < DIM_MIN) return 32'(DIM_MIN);
      if (32'(v) > MAX_DIM) return MAX_DIM;
      return 32'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_GRID_WIDTH: width_reg = data;
        REG_GRID_HEIGHT: height_reg = data;
        REG_WRAP_MODE: wrap = data[0];
        default: ;
      endcase
    endfunction

    function neighbor_result_t predict_neighbors(int unsigned x, int unsigned y);
      int unsigned w, h, cell_idx, up, down, right, left;
      int unsigned slot[4];
      bit bot, top, lft, rgt;
      neighbor_result_t r;
      w = dim_of(width_reg);
      h = dim_of(height_reg);
      r = '0;
      slot = '{default: 0};
      if (x >= w || y >= h) return r;
      cell_idx = y * w + x;
      up       = cell_idx + w;
      down     = cell_idx - w;
      right    = cell_idx + 1;
      left     = cell_idx - 1;
      bot = (y == 0);
      top = (y == h - 1);
      lft = (x == 0);
      rgt = (x == w - 1);
      if (wrap) begin
        if (top) up = x;
        if (bot) down = x + (h - 1) * w;
        if (rgt) right = y * w;
        if (lft) left = (w - 1) + y * w;
        slot = '{up, down, right, left};
        r.count = COUNT_FULL;
      end else if ((bot || top) && (lft || rgt)) begin
        slot[0] = lft ? right : left;
        slot[1] = bot ? up : down;
        r.count = COUNT_CORNER;
      end else if (bot) begin
        slot[0] = up; slot[1] = left; slot[2] = right;
        r.count = COUNT_EDGE;
      end else if (top) begin
        slot[0] = down; slot[1] = left; slot[2] = right;
        r.count = COUNT_EDGE;
      end else if (lft) begin
        slot[0] = up; slot[1] = down; slot[2] = right;
        r.count = COUNT_EDGE;
      end else if (rgt) begin
        slot[0] = up; slot[1] = down; slot[2] = left;
        r.count = COUNT_EDGE;
      end else begin
        slot = '{up, down, right, left};
        r.count = COUNT_FULL;
      end
      r.cell_idx = cell_idx[INDEX_W-1:0];
      for (int k = 0; k < 4; k++) r.nb[k] = slot[k][INDEX_W-1:0];
      r.inr = 1'b1;
      return r;
    endfunction

    function void note_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      expected_cells.push_back(predict_neighbors(32'(x), 32'(y)));
    endfunction

    function void compare_field(string field, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch expected %0d actual %0d", $time, field, exp_val, act_val);
      end
    endfunction

    function void check_result(neighbor_result_t act);
      neighbor_result_t exp;
      if (expected_cells.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result expected none actual cell_index %0d",
                   $time, act.cell_idx);
        return;
      end
      exp = expected_cells.pop_front();
      compare_field("cell_index", 32'(exp.cell_idx), 32'(act.cell_idx));
      for (int k = 0; k < 4; k++)
        compare_field($sformatf("neighbor_%0d", k), 32'(exp.nb[k]), 32'(act.nb[k]));
      compare_field("neighbor_count", 32'(exp.count), 32'(act.count));
      compare_field("in_range", 32'(exp.inr), 32'(act.inr));
    endfunction

    function int unsigned pending();
      return expected_cells.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   column = '0;
  logic [COORD_W-1:0]   row = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [INDEX_W-1:0]   cell_index;
  logic [INDEX_W-1:0]   neighbor_0;
  logic [INDEX_W-1:0]   neighbor_1;
  logic [INDEX_W-1:0]   neighbor_2;
  logic [INDEX_W-1:0]   neighbor_3;
  logic [COUNT_W-1:0]   neighbor_count;
  logic                 in_range;

  neighbor_scoreboard sb = new();
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;

  grid_neighbor_index_generator #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .column(column),
    .row(row),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_index(cell_index),
    .neighbor_0(neighbor_0),
    .neighbor_1(neighbor_1),
    .neighbor_2(neighbor_2),
    .neighbor_3(neighbor_3),
    .neighbor_count(neighbor_count),
    .in_range(in_range)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // transaction monitor
  always @(posedge clk) begin
    neighbor_result_t act;
    if (!rst) begin
      if (out_valid && out_ready) begin
        act.cell_idx = cell_index;
        act.nb[0]    = neighbor_0;
        act.nb[1]    = neighbor_1;
        act.nb[2]    = neighbor_2;
        act.nb[3]    = neighbor_3;
        act.count    = neighbor_count;
        act.inr      = in_range;
        sb.check_result(act);
      end
      if (in_valid && in_ready) sb.note_coord(column, row);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // result side backpressure
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        n = 1;
        while (n < HOLD_CYCLES) begin
          @(negedge clk);
          n++;
        end
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  task automatic send_coord(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    column   <= c;
    row      <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                          input logic [DIM_W-1:0] wrap_data);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [DIM_W-1:0]     val[3];
    idx = '{REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_WRAP_MODE};
    val = '{w, h, wrap_data};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // coordinates biased toward the grid edges and just outside
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned dim);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COORD_W'(dim - 1);
      2: return COORD_W'(dim);
      3: return COORD_W'($urandom_range(0, 1023));
      default: return COORD_W'($urandom_range(0, dim - 1));
    endcase
  endfunction

  initial begin
    logic [DIM_W-1:0] w, h;
    logic             wrap;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset grid, 2 by 2 periodic
    send_coord(0, 0);
    send_coord(1, 1);
    send_coord(1, 0);
    send_coord(2, 0);
    send_coord(1023, 1023);
    drain();

    // bounded 5 by 4: corners, edges, interior, outside
    set_grid(5, 4, 0);
    send_coord(0, 0);
    send_coord(4, 0);
    send_coord(0, 3);
    send_coord(4, 3);
    send_coord(2, 0);
    send_coord(2, 3);
    send_coord(0, 1);
    send_coord(4, 2);
    send_coord(2, 1);
    send_coord(5, 0);
    send_coord(0, 4);
    drain();

    // same grid periodic, upper data bits set on the mode write
    set_grid(5, 4, 11'h7fe | 11'h1);
    send_coord(0, 0);
    send_coord(4, 3);
    send_coord(2, 1);
    send_coord(4, 0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w = 1024; h = 1024; wrap = 1'b1; end
        1: begin w = 1024; h = 1024; wrap = 1'b0; end
        2: begin w = 0;    h = 1;    wrap = 1'b0; end
        3: begin w = 2047; h = 1025; wrap = 1'b1; end
        4: begin w = 1;    h = 2047; wrap = 1'b0; end
        5: begin w = 3;    h = 2;    wrap = 1'b0; end
        6: begin w = 2;    h = 3;    wrap = 1'b1; end
        default: begin
          w = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                 : $urandom_range(2, 64));
          h = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                 : $urandom_range(2, 64));
          wrap = 1'($urandom_range(0, 1));
        end
      endcase
      set_grid(w, h, {10'($urandom_range(0, 1023)), wrap});
      if (p == 0) begin
        // unmapped register index must be ignored
        cfg_valid <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= DIM_W'($urandom_range(0, 2047));
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
      end
      if (p == 2) hold_request = 1'b1;
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_coord(pick_coord(sb.dim_of(sb.width_reg)), pick_coord(sb.dim_of(sb.height_reg)));
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
